### hw/rtl/sfs_pkg.sv
// ----------------------------------------------------------------------------
// sfs_pkg: shared definitions for the sprite frame sequencer
// Field widths, register indexes, animation modes and the divider status.
// ----------------------------------------------------------------------------
`default_nettype none

package sfs_pkg;

  // default parameter values
  localparam int TIME_BITS_DEF  = 32;
  localparam int INDEX_BITS_DEF = 8;

  // fixed field widths
  localparam int MODE_W   = 3;
  localparam int COUNT_W  = 9;
  localparam int PERIOD_W = 24;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int LFSR_W   = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ANIM_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TIME   = 2'd3;

  // animation modes; the two remaining codes are undefined
  typedef enum logic [MODE_W-1:0] {
    MODE_CYCLE_FWD    = 3'd0,
    MODE_CYCLE_BACK   = 3'd1,
    MODE_ONESHOT_FWD  = 3'd2,
    MODE_ONESHOT_BACK = 3'd3,
    MODE_PINGPONG     = 3'd4,
    MODE_RANDOM       = 3'd5
  } anim_mode_t;

  // status of the serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### hw/rtl/sfs_div.sv
// ----------------------------------------------------------------------------
// sfs_div: bit-serial restoring divider
// Shifts one dividend bit into the partial remainder each cycle and gives
// quotient and remainder after DW steps, flagged by a one-cycle done.
// ----------------------------------------------------------------------------
`default_nettype none

module sfs_div #(
  parameter int DW = 34,
  parameter int VW = 24
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DW-1:0]     dividend,
  input  wire logic [VW-1:0]     divisor,
  output sfs_pkg::div_stat_t     stat,
  output logic      [DW-1:0]     quotient,
  output logic      [VW-1:0]     remainder
);
  import sfs_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW-1:0] q_r;
  logic [VW-1:0] rem_r;

  logic [VW:0] shifted;
  logic [VW:0] diff;
  logic        ge;

  // trial subtraction of the divisor
  always_comb begin
    shifted = {rem_r, q_r[DW-1]};
    diff    = shifted - {1'b0, divisor};
    ge      = shifted >= {1'b0, divisor};
  end

  // step counter and status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[VW-1:0] : shifted[VW-1:0];
      q_r   <= {q_r[DW-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

### hw/rtl/sprite_frame_sequencer.sv
// ----------------------------------------------------------------------------
// sprite_frame_sequencer: sprite animation frame index generator
// Maps a tick count to a frame number under cycle, oneshot, pingpong and
// random animation modes.
// ----------------------------------------------------------------------------
// Each input word carries the current tick count; one result word follows
// with the frame index, a flag once a full period has elapsed and a flag when
// the time lies before the start tick. Items are handled one at a time, and a
// new word is taken as soon as the previous one has left the datapath, even
// while its result still waits in the output register. The divider works on
// DW bits, where DW is the larger of TIME_BITS and 34: a single bit-serial
// divider is used twice, once for the phase within the period and once for
// the scaled frame number, at one bit per cycle. Random mode and the undefined
// mode codes skip the second pass. Configuration is to be written by the user
// only while the block is idle; the block itself does not enforce this.
`default_nettype none

module sprite_frame_sequencer #(
  parameter int TIME_BITS  = sfs_pkg::TIME_BITS_DEF,
  parameter int INDEX_BITS = sfs_pkg::INDEX_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // now_ticks
  input  wire logic [((TIME_BITS+7)/8)*8-1:0]      in_tdata,
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // frame_index
  output logic      [((INDEX_BITS+7)/8)*8-1:0]     out_tdata,
  // cycle_done, time_before_start
  output logic      [1:0]                          out_tuser,
  // configuration
  input  wire logic                                cfg_we,
  input  wire logic [sfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [sfs_pkg::CFG_W-1:0]           cfg_wdata
);
  import sfs_pkg::*;

  localparam int OUT_W  = ((INDEX_BITS + 7) / 8) * 8;
  localparam int PROD_W = PERIOD_W + 1 + COUNT_W;
  localparam int DW     = (TIME_BITS > PROD_W) ? TIME_BITS : PROD_W;
  localparam int RND_W  = LFSR_W + COUNT_W;
  localparam int HELD_W = COUNT_W - 1;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MOD  = 6'b000010,
    ST_PREP = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  // galois lfsr step
  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] t;
    t = s >> 1;
    if (s[0]) begin
      t = t ^ LFSR_W'(16'hB400);
    end
    return t;
  endfunction

  // configuration registers
  logic [MODE_W-1:0]    mode_r;
  logic [COUNT_W-1:0]   count_r;
  logic [PERIOD_W-1:0]  period_r;
  logic [TIME_BITS-1:0] start_r;

  // random mode state
  logic [HELD_W-1:0]    held_frame_r;
  logic [TIME_BITS-1:0] held_time_r;
  logic                 held_valid_r;
  logic [LFSR_W-1:0]    lfsr_r;

  // item registers
  state_t               state_r, state_nxt;
  logic [TIME_BITS-1:0] now_r;
  logic                 before_r;
  logic                 done_r;
  logic [PERIOD_W-1:0]  phase_r;
  logic [PERIOD_W:0]    base_r;
  logic                 lo_r;
  logic                 pick_r;
  logic [COUNT_W-1:0]   q_r;

  // output register
  logic                  out_valid_r;
  logic [INDEX_BITS-1:0] out_idx_r;
  logic                  out_done_r;
  logic                  out_before_r;

  // effective frame count and period
  logic [COUNT_W-1:0]  n_eff;
  logic [PERIOD_W-1:0] per_eff;

  always_comb begin
    if (count_r == '0) begin
      n_eff = COUNT_W'(1);
    end else if (count_r > COUNT_W'(256)) begin
      n_eff = COUNT_W'(256);
    end else begin
      n_eff = count_r;
    end
    per_eff = (period_r == '0) ? PERIOD_W'(1) : period_r;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_CYCLE_FWD;
      count_r  <= COUNT_W'(1);
      period_r <= PERIOD_W'(1);
      start_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ANIM_MODE:    mode_r   <= cfg_wdata[MODE_W-1:0];
        CFG_FRAME_COUNT:  count_r  <= cfg_wdata[COUNT_W-1:0];
        CFG_PERIOD_TICKS: period_r <= cfg_wdata[PERIOD_W-1:0];
        CFG_START_TIME:   start_r  <= TIME_BITS'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // input acceptance and elapsed time
  logic                 in_acc;
  logic [TIME_BITS-1:0] now_in;
  logic                 before_in;
  logic [TIME_BITS-1:0] elapsed_in;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    now_in     = in_tdata[TIME_BITS-1:0];
    before_in  = now_in < start_r;
    elapsed_in = before_in ? '0 : (now_in - start_r);
  end

  // shared divider
  div_stat_t           div_stat;
  logic                div_start;
  logic [DW-1:0]       div_dividend;
  logic [DW-1:0]       div_quot;
  logic [PERIOD_W-1:0] div_rem;
  logic [COUNT_W-1:0]  fac;
  logic [PROD_W-1:0]   prod;

  always_comb begin
    fac  = (mode_r == MODE_PINGPONG) ? (n_eff - 1'b1) : n_eff;
    prod = PROD_W'(base_r) * PROD_W'(fac);
  end

  assign div_start    = in_acc || (state_r == ST_MUL);
  assign div_dividend = in_acc ? DW'(elapsed_in) : DW'(prod);

  sfs_div #(
    .DW (DW),
    .VW (PERIOD_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (per_eff),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // pingpong fold and random repick test
  logic [PERIOD_W:0]    twice;
  logic                 lo_nxt;
  logic [TIME_BITS-1:0] since_pick;
  logic                 pick_nxt;

  always_comb begin
    twice      = {phase_r, 1'b0};
    lo_nxt     = twice < {1'b0, per_eff};
    since_pick = now_r - held_time_r;
    pick_nxt   = !held_valid_r || (DW'(since_pick) >= DW'(per_eff));
  end

  // final index selection
  logic                 out_free;
  logic [LFSR_W-1:0]    lfsr_nxt;
  logic [RND_W-1:0]     rnd_prod;
  logic [HELD_W-1:0]    rnd_frame;
  logic [COUNT_W-1:0]   n_last;
  logic [COUNT_W-1:0]   idx;
  logic                 fin_go;

  always_comb begin
    out_free  = !out_valid_r || out_tready;
    fin_go    = (state_r == ST_FIN) && out_free;
    lfsr_nxt  = lfsr_step(lfsr_r);
    rnd_prod  = RND_W'(lfsr_nxt) * RND_W'(n_eff);
    rnd_frame = rnd_prod[LFSR_W +: HELD_W];
    n_last    = n_eff - 1'b1;
    case (mode_r)
      MODE_CYCLE_FWD:    idx = q_r;
      MODE_CYCLE_BACK:   idx = n_last - q_r;
      MODE_ONESHOT_FWD:  idx = done_r ? n_last : q_r;
      MODE_ONESHOT_BACK: idx = done_r ? '0 : (n_last - q_r);
      MODE_PINGPONG: begin
        if (n_eff == COUNT_W'(1)) begin
          idx = '0;
        end else begin
          idx = lo_r ? q_r : (n_last - q_r);
        end
      end
      MODE_RANDOM: begin
        idx = {1'b0, (pick_r ? rnd_frame : held_frame_r)};
      end
      default:           idx = '0;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (div_stat.done) state_nxt = ST_PREP;
      end
      ST_PREP: begin
        if (mode_r == MODE_CYCLE_FWD || mode_r == MODE_CYCLE_BACK ||
            mode_r == MODE_ONESHOT_FWD || mode_r == MODE_ONESHOT_BACK ||
            mode_r == MODE_PINGPONG) begin
          state_nxt = ST_MUL;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_MUL: state_nxt = ST_DIV;
      ST_DIV: begin
        if (div_stat.done) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // item datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r    <= now_in;
      before_r <= before_in;
      done_r   <= DW'(elapsed_in) >= DW'(per_eff);
    end
    if (state_r == ST_MOD && div_stat.done) begin
      phase_r <= div_rem;
    end
    if (state_r == ST_PREP) begin
      lo_r   <= lo_nxt;
      pick_r <= pick_nxt;
      if (mode_r == MODE_PINGPONG) begin
        base_r <= lo_nxt ? twice : (twice - {1'b0, per_eff});
      end else begin
        base_r <= {1'b0, phase_r};
      end
    end
    if (state_r == ST_DIV && div_stat.done) begin
      q_r <= div_quot[COUNT_W-1:0];
    end
  end

  // random mode state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_frame_r <= '0;
      held_time_r  <= '0;
      held_valid_r <= 1'b0;
      lfsr_r       <= LFSR_W'(1);
    end else if (fin_go && mode_r == MODE_RANDOM && pick_r) begin
      lfsr_r       <= lfsr_nxt;
      held_frame_r <= rnd_frame;
      held_time_r  <= now_r - TIME_BITS'(phase_r);
      held_valid_r <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_idx_r    <= INDEX_BITS'(idx);
      out_done_r   <= done_r;
      out_before_r <= before_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(out_idx_r);
  assign out_tuser  = {out_before_r, out_done_r};

endmodule

`default_nettype wire
